@@ rtl/core/eodc_pkg.sv @@
package eodc_pkg;

   localparam int unsigned EPOCH_YEAR = 1970;

   // time units in microseconds, 57 bits to hold epoch_us plus the rounding half
   localparam logic [56:0] US_PER_SEC       = 57'd1000000;
   localparam logic [56:0] US_PER_8SEC      = 57'd8000000;
   localparam logic [56:0] US_PER_MIN       = 57'd60000000;
   localparam logic [56:0] US_PER_8MIN      = 57'd480000000;
   localparam logic [56:0] US_PER_HOUR      = 57'd3600000000;
   localparam logic [56:0] US_PER_4HOUR     = 57'd14400000000;
   localparam logic [56:0] US_PER_DAY       = 57'd86400000000;
   localparam logic [56:0] US_PER_16DAY     = 57'd1382400000000;
   localparam logic [56:0] US_PER_YEAR      = 57'd31536000000000;
   localparam logic [56:0] US_PER_LEAP_YEAR = 57'd31622400000000;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_MUL,
      ST_SPLIT,
      ST_DONE
   } state_type;

   // time-of-year split steps, coarse then fine per field
   typedef enum logic [3:0] {
      SP_DAY16,
      SP_DAY1,
      SP_HOUR4,
      SP_HOUR1,
      SP_MIN8,
      SP_MIN1,
      SP_SEC8,
      SP_SEC1,
      SP_MSEC
   } split_step_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_INVALID  = 2'd1,
      STAT_OVERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic        op;
      logic [11:0] year;
      logic [8:0]  day_of_year;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [9:0]  millisecond;
      logic [55:0] epoch_us;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [55:0] time_us;
      logic [11:0] year_out;
      logic [8:0]  day_out;
      logic [4:0]  hour_out;
      logic [5:0]  minute_out;
      logic [5:0]  second_out;
      logic [9:0]  msec_out;
   } rsp_word_type;

   // Gregorian leap rule; y / 100 by reciprocal multiply, exact for 12-bit y
   function automatic logic is_leap(input logic [11:0] y);
      logic [24:0] prod;
      logic [11:0] q100;
      logic        div100;
      logic        div400;
      begin
         prod   = 25'(y) * 25'd5243;
         q100   = 12'(prod >> 19);
         div100 = (12'(q100 * 12'd100) == y);
         div400 = div100 && (q100[1:0] == 2'b00);
         is_leap = ((y[1:0] == 2'b00) && !div100) || div400;
      end
   endfunction

endpackage

@@ rtl/core/eodc_if.sv @@
interface eodc_req_if;
   import eodc_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface eodc_rsp_if;
   import eodc_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/eodc_divider.sv @@
// Millisecond count of a sub-second remainder: x / 1000 taken as (x >> 3) / 125
// by reciprocal multiply; exact for any x below one million.
module eodc_divider (
   input  logic [19:0] numer,
   output logic [9:0]  quot
);
   localparam logic [17:0] RECIP_125 = 18'd134218;

   logic [34:0] prod;

   assign prod = 35'(numer[19:3]) * 35'(RECIP_125);
   assign quot = 10'(prod >> 24);
endmodule

@@ rtl/core/epoch_ordinal_date_convert_unit.sv @@
// Calendar <-> epoch time converter.
// Channels: req (source drives valid/data, unit drives ready) carries one
// word with op, calendar fields and epoch_us; rsp carries one result word
// per request word. Op 0 checks the fields and walks year lengths from 1970
// to the given year, then forms microseconds by multiply-add steps.
// Op 1 adds the rounding half millisecond, walks whole years off the time
// (one compare-subtract per cycle), then splits the rest of the year into
// days, hours, minutes and seconds by coarse and fine subtract steps, and
// takes the millisecond by a reciprocal multiply.
// The year walk, one year per cycle, dominates the time to a result.
// One word is in flight at a time: req_ready is low from acceptance until
// the result has been taken. A result waits in the output register while
// rsp_ready is low. Reset is synchronous and returns the unit to idle with
// no result pending.
module epoch_ordinal_date_convert_unit #(
   parameter int unsigned MAX_YEAR = 4095
) (
   input  logic  clock,
   input  logic  reset,
   eodc_req_if.sink   req,
   eodc_rsp_if.source rsp
);
   import eodc_pkg::*;

   localparam logic [11:0] YLIM = (MAX_YEAR > 4095) ? 12'd4095 : 12'(MAX_YEAR);

   state_type      state_ff, state_in;
   split_step_type split_ff, split_in;
   req_word_type   in_ff;
   rsp_word_type   out_ff, out_in;
   logic           out_valid_ff, out_valid_in;
   logic [11:0]    year_ff, year_in;
   logic [56:0]    acc_ff, acc_in;
   logic [19:0]    days_ff, days_in;
   logic [2:0]     step_ff, step_in;

   logic           accept;
   logic           bad;
   logic [8:0]     ylen;
   logic [56:0]    ylen_us;
   logic [56:0]    unit_us;
   logic [9:0]     ms_q;

   eodc_divider u_msec (
      .numer (acc_ff[19:0]),
      .quot  (ms_q)
   );

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE) && !out_valid_ff;
   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_ff;
   assign ylen      = is_leap(year_ff) ? 9'd366 : 9'd365;
   assign ylen_us   = is_leap(year_ff) ? US_PER_LEAP_YEAR : US_PER_YEAR;
   assign bad = (req.data.year < 12'(EPOCH_YEAR)) || (req.data.day_of_year == 9'd0) ||
                (req.data.day_of_year > 9'd366) || (req.data.hour > 5'd23) ||
                (req.data.minute > 6'd59) || (req.data.second > 6'd59) ||
                (req.data.millisecond > 10'd999);

   // subtract unit of each split step
   always_comb begin
      unique case (split_ff)
         SP_DAY16: unit_us = US_PER_16DAY;
         SP_DAY1:  unit_us = US_PER_DAY;
         SP_HOUR4: unit_us = US_PER_4HOUR;
         SP_HOUR1: unit_us = US_PER_HOUR;
         SP_MIN8:  unit_us = US_PER_8MIN;
         SP_MIN1:  unit_us = US_PER_MIN;
         SP_SEC8:  unit_us = US_PER_8SEC;
         default:  unit_us = US_PER_SEC;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) begin
            if (req.data.op) state_in = ST_WALK;
            else if (bad || req.data.year > YLIM) state_in = ST_DONE;
            else state_in = ST_WALK;
         end
         ST_WALK: begin
            if (in_ff.op) begin
               if (acc_ff < ylen_us) state_in = ST_SPLIT;
               else if (year_ff >= YLIM) state_in = ST_DONE;
            end else if (year_ff == in_ff.year) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: if (step_ff == 3'd4) state_in = ST_DONE;
         ST_SPLIT: if (split_ff == SP_MSEC) state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath sequencing
   always_comb begin
      year_in      = year_ff;
      acc_in       = acc_ff;
      days_in      = days_ff;
      step_in      = step_ff;
      split_in     = split_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp.ready) out_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            year_in  = 12'(EPOCH_YEAR);
            days_in  = '0;
            step_in  = '0;
            split_in = SP_DAY16;
            if (accept) begin
               out_in = '0;
               acc_in = 57'(req.data.epoch_us) + 57'd500;
               if (!req.data.op && bad) out_in.status = STAT_INVALID;
               else if (!req.data.op && req.data.year > YLIM)
                  out_in.status = STAT_OVERFLOW;
            end
         end
         ST_WALK: begin
            if (in_ff.op) begin
               if (acc_ff < ylen_us) begin
                  split_in = SP_DAY16;
               end else if (year_ff >= YLIM) begin
                  out_in.status = STAT_OVERFLOW;
               end else begin
                  acc_in  = acc_ff - ylen_us;
                  year_in = year_ff + 12'd1;
               end
            end else if (year_ff != in_ff.year) begin
               days_in = days_ff + 20'(ylen);
               year_in = year_ff + 12'd1;
            end else begin
               days_in = days_ff + 20'(in_ff.day_of_year - 9'd1);
               step_in = 3'd0;
            end
         end
         ST_MUL: begin
            // days*86400 + h*3600 + m*60 + s, then *1e6 + ms*1000
            unique case (step_ff)
               3'd0: acc_in = 57'(days_ff) * 57'd86400;
               3'd1: acc_in = acc_ff + 57'(in_ff.hour) * 57'd3600 +
                              57'(in_ff.minute) * 57'd60 + 57'(in_ff.second);
               3'd2: acc_in = 57'(acc_ff[35:0]) * 57'd1000000;
               3'd3: acc_in = acc_ff + 57'(in_ff.millisecond) * 57'd1000;
               default: out_in.time_us = acc_ff[55:0];
            endcase
            step_in = step_ff + 3'd1;
         end
         ST_SPLIT: begin
            // take off one unit per cycle while it fits, then the next finer unit
            if (split_ff == SP_MSEC) begin
               out_in.msec_out = ms_q;
               out_in.year_out = year_ff;
               out_in.day_out  = out_ff.day_out + 9'd1;
            end else if (acc_ff >= unit_us) begin
               acc_in = acc_ff - unit_us;
               unique case (split_ff)
                  SP_DAY16: out_in.day_out    = out_ff.day_out + 9'd16;
                  SP_DAY1:  out_in.day_out    = out_ff.day_out + 9'd1;
                  SP_HOUR4: out_in.hour_out   = out_ff.hour_out + 5'd4;
                  SP_HOUR1: out_in.hour_out   = out_ff.hour_out + 5'd1;
                  SP_MIN8:  out_in.minute_out = out_ff.minute_out + 6'd8;
                  SP_MIN1:  out_in.minute_out = out_ff.minute_out + 6'd1;
                  SP_SEC8:  out_in.second_out = out_ff.second_out + 6'd8;
                  default:  out_in.second_out = out_ff.second_out + 6'd1;
               endcase
            end else begin
               split_in = split_step_type'(split_ff + 4'd1);
            end
         end
         ST_DONE: out_valid_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
         split_ff     <= SP_DAY16;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
         split_ff     <= split_in;
      end
      if (accept) in_ff <= req.data;
      year_ff <= year_in;
      acc_ff  <= acc_in;
      days_ff <= days_in;
      out_ff  <= out_in;
   end

   // a result never coexists with work in progress
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (state_ff == ST_IDLE)) else $error("result during work");
   // a failed conversion carries zero payload
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.status != STAT_OK) |-> (out_ff.time_us == '0 &&
      out_ff.year_out == '0)) else $error("nonzero fields on failure");
   // walk never passes the requested year on op 0
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && !in_ff.op) |-> (year_ff <= in_ff.year))
      else $error("year walk overran");
endmodule

@@ bench/epoch_ordinal_date_convert_unit_tb.sv @@
`timescale 1ns / 1ps

module epoch_ordinal_date_convert_unit_tb;
   import eodc_pkg::*;

   localparam int unsigned YEAR_LIMIT = 4095;
   localparam int unsigned WATCHDOG_LIMIT = 60000;
   localparam longint unsigned US_PER_DAY = 64'd86400000000;

   // op codes
   localparam logic OP_TO_EPOCH = 1'b0;
   localparam logic OP_TO_FIELDS = 1'b1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   error_count = 0;
   int   idle_cycles = 0;

   eodc_req_if req_if ();
   eodc_rsp_if rsp_if ();

   epoch_ordinal_date_convert_unit #(.MAX_YEAR(YEAR_LIMIT)) u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mismatch report
   task automatic report_mismatch(input string what);
      $display("[%0t] error: %s", $realtime, what);
      error_count++;
   endtask

   function automatic int unsigned days_in_year(input int unsigned y);
      return (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0) ? 366 : 365;
   endfunction

   // date conversion predictor
   function automatic rsp_word_type convert_date(input req_word_type w);
      rsp_word_type r;
      longint unsigned days, secs, rem, ms, sod;
      int unsigned y;
      bit found;
      r = '0;
      if (w.op == OP_TO_EPOCH) begin
         if (w.year < EPOCH_YEAR || w.day_of_year < 1 || w.day_of_year > 366 ||
             w.hour > 23 || w.minute > 59 || w.second > 59 || w.millisecond > 999) begin
            r.status = STAT_INVALID;
         end else if (w.year > YEAR_LIMIT) begin
            r.status = STAT_OVERFLOW;
         end else begin
            days = 0;
            for (y = EPOCH_YEAR; y < w.year; y++) days += days_in_year(y);
            days += w.day_of_year - 1;
            secs = days * 86400 + w.hour * 3600 + w.minute * 60 + w.second;
            r.time_us = 56'(secs * 1000000 + w.millisecond * 1000);
         end
      end else begin
         secs = w.epoch_us / 1000000;
         rem = w.epoch_us % 1000000;
         ms = (rem + 500) / 1000;
         if (ms >= 1000) begin
            ms = 0;
            secs++;
         end
         days = secs / 86400;
         sod = secs % 86400;
         found = 1'b0;
         for (y = EPOCH_YEAR; y <= YEAR_LIMIT; y++) begin
            if (days < days_in_year(y)) begin
               found = 1'b1;
               break;
            end
            days -= days_in_year(y);
         end
         if (!found) begin
            r.status = STAT_OVERFLOW;
         end else begin
            r.year_out = 12'(y);
            r.day_out = 9'(days + 1);
            r.hour_out = 5'(sod / 3600);
            r.minute_out = 6'((sod % 3600) / 60);
            r.second_out = 6'(sod % 60);
            r.msec_out = 10'(ms);
         end
      end
      return r;
   endfunction

   class date_scoreboard;
      rsp_word_type pending_dates[$];

      function void note_request(input req_word_type w);
         pending_dates.push_back(convert_date(w));
      endfunction

      task check_result(input rsp_word_type got);
         rsp_word_type exp_w;
         if (pending_dates.size() == 0) begin
            report_mismatch("result word with nothing pending");
            return;
         end
         exp_w = pending_dates.pop_front();
         if (got.status !== exp_w.status)
            report_mismatch($sformatf("status %0d exp %0d", got.status, exp_w.status));
         if (got.time_us !== exp_w.time_us)
            report_mismatch($sformatf("time_us %0d exp %0d", got.time_us, exp_w.time_us));
         if (got.year_out !== exp_w.year_out)
            report_mismatch($sformatf("year_out %0d exp %0d", got.year_out, exp_w.year_out));
         if (got.day_out !== exp_w.day_out)
            report_mismatch($sformatf("day_out %0d exp %0d", got.day_out, exp_w.day_out));
         if (got.hour_out !== exp_w.hour_out)
            report_mismatch($sformatf("hour_out %0d exp %0d", got.hour_out, exp_w.hour_out));
         if (got.minute_out !== exp_w.minute_out)
            report_mismatch($sformatf("minute_out %0d exp %0d", got.minute_out,
                                      exp_w.minute_out));
         if (got.second_out !== exp_w.second_out)
            report_mismatch($sformatf("second_out %0d exp %0d", got.second_out,
                                      exp_w.second_out));
         if (got.msec_out !== exp_w.msec_out)
            report_mismatch($sformatf("msec_out %0d exp %0d", got.msec_out, exp_w.msec_out));
      endtask
   endclass

   date_scoreboard sb = new();

   function automatic int unsigned random_gap();
      if ($urandom_range(0, 2) == 0) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
      return $urandom_range(1, 4);
   endfunction

   // send one word, with a random gap before it unless no_gap is set; valid stays up until the next word
   task automatic send_word(input req_word_type w, input bit no_gap);
      int unsigned gap;
      gap = no_gap ? 0 : random_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data <= w;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_request(w);
   endtask

   // drop valid and hold off until every result is back
   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_dates.size() != 0) @(posedge clock);
   endtask

   function automatic req_word_type fields_word(input int unsigned yr, input int unsigned da,
                                                input int unsigned hr, input int unsigned mn,
                                                input int unsigned sc, input int unsigned ms);
      req_word_type w;
      w = '0;
      w.op = OP_TO_EPOCH;
      w.year = 12'(yr);
      w.day_of_year = 9'(da);
      w.hour = 5'(hr);
      w.minute = 6'(mn);
      w.second = 6'(sc);
      w.millisecond = 10'(ms);
      w.epoch_us = 56'({$urandom, $urandom});
      return w;
   endfunction

   function automatic req_word_type epoch_word(input longint unsigned t);
      req_word_type w;
      w = '0;
      w.op = OP_TO_FIELDS;
      w.epoch_us = 56'(t);
      w.year = 12'($urandom);
      w.day_of_year = 9'($urandom);
      w.hour = 5'($urandom);
      w.minute = 6'($urandom);
      w.second = 6'($urandom);
      w.millisecond = 10'($urandom);
      return w;
   endfunction

   function automatic longint unsigned rand_epoch();
      longint unsigned t;
      case ($urandom_range(0, 5))
         0: t = {$urandom, $urandom};
         1: t = longint'($urandom_range(0, 200)) * US_PER_DAY * 365
                + {$urandom, $urandom} % (US_PER_DAY * 366);
         2: t = (longint'($urandom_range(0, 100000)) * 1000000) + 499 + $urandom_range(0, 2);
         3: t = longint'($urandom_range(0, 2000)) * US_PER_DAY * 365 + 999500
                + $urandom_range(0, 499);
         default: t = {$urandom, $urandom} % (US_PER_DAY * 36525 * 3);
      endcase
      return t & 64'h00FF_FFFF_FFFF_FFFF;
   endfunction

   // stimulus
   initial begin
      req_word_type w;
      req_if.valid = 1'b0;
      req_if.data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, invalid fields, year limit, rounding carry
      send_word(fields_word(1970, 1, 0, 0, 0, 0), 1'b0);
      send_word(fields_word(YEAR_LIMIT, 366, 23, 59, 59, 999), 1'b0);
      send_word(fields_word(1969, 1, 0, 0, 0, 0), 1'b0);
      send_word(fields_word(0, 0, 31, 63, 63, 1023), 1'b0);
      send_word(fields_word(2000, 367, 0, 0, 0, 0), 1'b0);
      send_word(fields_word(2000, 511, 0, 0, 0, 0), 1'b0);
      send_word(fields_word(2001, 366, 0, 0, 0, 0), 1'b0);
      send_word(fields_word(2100, 60, 24, 0, 0, 0), 1'b0);
      send_word(fields_word(2024, 60, 0, 60, 0, 0), 1'b0);
      send_word(fields_word(2024, 60, 0, 0, 60, 0), 1'b0);
      send_word(fields_word(2024, 60, 0, 0, 0, 1000), 1'b0);
      send_word(fields_word(2400, 366, 12, 30, 30, 500), 1'b0);
      send_word(epoch_word(0), 1'b0);
      send_word(epoch_word(499), 1'b0);
      send_word(epoch_word(500), 1'b0);
      send_word(epoch_word(999500), 1'b0);
      send_word(epoch_word(US_PER_DAY - 1), 1'b0);
      send_word(epoch_word(US_PER_DAY * 365), 1'b0);
      send_word(epoch_word(64'h00FF_FFFF_FFFF_FFFF), 1'b0);
      send_word(epoch_word(64'd67090118399999499), 1'b0);
      send_word(epoch_word(64'd67090118399999500), 1'b0);

      // hold off until every result is back
      drain_results();

      for (int i = 0; i < 270; i++) begin
         if ($urandom_range(0, 1) == 0) begin
            if ($urandom_range(0, 4) == 0)
               w = fields_word($urandom_range(0, 4095), $urandom_range(0, 511),
                               $urandom_range(0, 31), $urandom_range(0, 63),
                               $urandom_range(0, 63), $urandom_range(0, 1023));
            else
               w = fields_word($urandom_range(0, 3) == 0 ? $urandom_range(1970, 4095)
                               : $urandom_range(1970, 2300), $urandom_range(1, 366),
                               $urandom_range(0, 23), $urandom_range(0, 59),
                               $urandom_range(0, 59), $urandom_range(0, 999));
         end else begin
            w = epoch_word(rand_epoch());
         end
         send_word(w, $urandom_range(0, 3) == 0);
         if (i == 135) drain_results();
      end

      drain_results();
      repeat (50) @(posedge clock);
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // result side: random stalls with unstalled stretches
   initial begin
      int unsigned stall;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            stall--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall = random_gap();
         end
      end
   end

   // check accepted results
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.data);
   end

   // watchdog on handshake inactivity
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

endmodule
